// ----- src/absolute_value_min_heap_top_assert.svh -----
// ----------------------------------------------------------------------------
// absolute value min heap assertion macros
// concurrent checks clocked on i_clk, with and without reset qualification
// ----------------------------------------------------------------------------
`ifndef ABSOLUTE_VALUE_MIN_HEAP_TOP_ASSERT_SVH
`define ABSOLUTE_VALUE_MIN_HEAP_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define AVMH_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("avmh check failed");

`define AVMH_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("avmh check failed");

`else

`define AVMH_ASSERT(label, prop)

`define AVMH_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- src/avmh_pkg.sv -----
// ----------------------------------------------------------------------------
// avmh_pkg
// shared types, status codes and the ordering function of the min heap
// ----------------------------------------------------------------------------
`default_nettype none

package avmh_pkg;

    localparam int unsigned ValueW  = 32;
    localparam int unsigned StatusW = 2;

    typedef logic [ValueW-1:0]  t_value;
    typedef logic [StatusW-1:0] t_status;

    localparam t_status STATUS_POPPED = 2'd0;
    localparam t_status STATUS_EMPTY  = 2'd1;
    localparam t_status STATUS_FULL   = 2'd2;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_cmd;

    function automatic t_value magnitude(input t_value v);
        magnitude = v[ValueW-1] ? (t_value'(0) - v) : v;
    endfunction

    // true when a ranks strictly before b: smaller magnitude, then smaller signed value
    function automatic logic ranks_before(input t_value a, input t_value b);
        t_value ma;
        t_value mb;
        ma = magnitude(a);
        mb = magnitude(b);
        if (ma != mb) begin
            ranks_before = (ma < mb);
        end else begin
            ranks_before = ($signed(a) < $signed(b));
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/absolute_value_min_heap_top.sv -----
// ----------------------------------------------------------------------------
// absolute_value_min_heap_top
// priority queue returning the entry of smallest absolute value
// ----------------------------------------------------------------------------
// Takes one item per clock whenever busy is low (busy is high only in reset
// and the cycle after it). A nonzero item is inserted; a zero item removes
// the entry of smallest absolute value, ties going to the smaller signed
// value. Entries are kept sorted in a row of HEAP_CAPACITY cells, each with
// its own comparator, so an insert or a removal completes in the cycle it is
// accepted and any result appears on the next cycle for exactly one cycle,
// marked by o_valid; the receiver must take it then. A successful insert gives
// no result; removal from an empty queue gives status empty, insertion into a
// full queue is dropped with status full, both with a zero value.
// ----------------------------------------------------------------------------
`default_nettype none

`include "absolute_value_min_heap_top_assert.svh"

module absolute_value_min_heap_top #(
    parameter int unsigned HEAP_CAPACITY = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire avmh_pkg::t_value    i_item_value,
    output      logic                busy,
    output      logic                o_valid,
    output      avmh_pkg::t_value    o_popped_value,
    output      avmh_pkg::t_status   o_status
);
    import avmh_pkg::*;

    localparam int unsigned CountW = $clog2(HEAP_CAPACITY + 1);
    localparam logic [CountW-1:0] CapCount = CountW'(HEAP_CAPACITY);

    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic              r_ready;
    logic              r_out_valid;
    t_value            r_out_value;
    t_status           r_out_status;
    logic              n_out_valid;
    t_value            n_out_value;
    t_status           n_out_status;

    logic      w_accept;
    logic      w_is_pop;
    logic      w_full;
    logic      w_empty_q;
    t_cell_cmd w_cmd;

    t_value w_val    [HEAP_CAPACITY];
    logic   w_before [HEAP_CAPACITY];

    assign busy      = !r_ready;
    assign w_accept  = start && !busy;
    assign w_is_pop  = (i_item_value == t_value'(0));
    assign w_full    = (r_count == CapCount);
    assign w_empty_q = (r_count == '0);

    assign w_cmd.push = w_accept && !w_is_pop && !w_full;
    assign w_cmd.pop  = w_accept && w_is_pop && !w_empty_q;

    for (genvar gi = 0; gi < HEAP_CAPACITY; gi++) begin : g_cell
        localparam logic [CountW-1:0] Idx = CountW'(gi);
        logic   w_prev_before;
        t_value w_prev_value;
        t_value w_next_value;

        if (gi == 0) begin : g_first
            assign w_prev_before = 1'b0;
            assign w_prev_value  = '0;
        end else begin : g_mid
            assign w_prev_before = w_before[gi-1];
            assign w_prev_value  = w_val[gi-1];
        end

        if (gi == HEAP_CAPACITY - 1) begin : g_last
            assign w_next_value = w_val[gi];
        end else begin : g_inner
            assign w_next_value = w_val[gi+1];
        end

        avmh_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_item        (i_item_value),
            .i_empty       (r_count <= Idx),
            .i_prev_before (w_prev_before),
            .i_prev_value  (w_prev_value),
            .i_next_value  (w_next_value),
            .o_before      (w_before[gi]),
            .o_value       (w_val[gi])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_valid  = 1'b0;
        n_out_value  = '0;
        n_out_status = STATUS_POPPED;
        if (w_accept) begin
            priority if (!w_is_pop && w_full) begin
                n_out_valid  = 1'b1;
                n_out_status = STATUS_FULL;
            end else if (!w_is_pop) begin
                n_count = r_count + CountW'(1);
            end else if (w_empty_q) begin
                n_out_valid  = 1'b1;
                n_out_status = STATUS_EMPTY;
            end else begin
                n_count      = r_count - CountW'(1);
                n_out_valid  = 1'b1;
                n_out_value  = w_val[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_ready     <= 1'b1;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_valid        = r_out_valid;
    assign o_popped_value = r_out_value;
    assign o_status       = r_out_status;

    `AVMH_ASSERT(a_result_follows, (w_accept && (w_is_pop || w_full)) |=> o_valid)
    `AVMH_ASSERT(a_result_has_cause, o_valid |-> $past(w_accept))
    `AVMH_ASSERT(a_no_value_on_fail,
        (o_valid && o_status != STATUS_POPPED) |-> (o_popped_value == t_value'(0)))
    `AVMH_ASSERT_ALWAYS(a_count_bound, !i_rst_n || (r_count <= CapCount))
    `AVMH_ASSERT(a_count_holds,
        (!$past(w_accept) && $past(i_rst_n)) |-> (r_count == $past(r_count)))

endmodule

`default_nettype wire

// ----- src/avmh_cell.sv -----
// ----------------------------------------------------------------------------
// avmh_cell
// one slot of the sorted row; compares the incoming item with its own entry
// ----------------------------------------------------------------------------
`default_nettype none

module avmh_cell (
    input  wire logic               i_clk,
    input  wire avmh_pkg::t_cell_cmd i_cmd,
    input  wire avmh_pkg::t_value   i_item,
    input  wire logic               i_empty,
    input  wire logic               i_prev_before,
    input  wire avmh_pkg::t_value   i_prev_value,
    input  wire avmh_pkg::t_value   i_next_value,
    output      logic               o_before,
    output      avmh_pkg::t_value   o_value
);
    import avmh_pkg::*;

    t_value r_value;
    t_value n_value;

    // an empty slot ranks after every item
    assign o_before = i_empty || ranks_before(i_item, r_value);
    assign o_value  = r_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.pop) begin
            n_value = i_next_value;
        end else if (i_cmd.push) begin
            // left neighbor shifts right when the item lands further left
            if (i_prev_before) begin
                n_value = i_prev_value;
            end else if (o_before) begin
                n_value = i_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire
